// ===== hdl/status_report_timer_macros.svh =====
// Assertion macros shared by the status report timer checkers.
`ifndef STATUS_REPORT_TIMER_MACROS_SVH
`define STATUS_REPORT_TIMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("status_report_timer: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("status_report_timer: assertion failed");

`endif

// ===== hdl/srt_pkg.sv =====
// Types and constants of the status report timer.
`default_nettype none

package srt_pkg;

   // Event codes
   localparam logic [3:0] FUNC_TICK       = 4'd0;
   localparam logic [3:0] FUNC_SCAN       = 4'd1;
   localparam logic [3:0] FUNC_SET_BATT   = 4'd2;
   localparam logic [3:0] FUNC_SET_TEMP   = 4'd3;
   localparam logic [3:0] FUNC_SET_FAULT  = 4'd4;
   localparam logic [3:0] FUNC_CLR_FAULT  = 4'd5;
   localparam logic [3:0] FUNC_SET_MODULE = 4'd6;
   localparam logic [3:0] FUNC_CLR_MODULE = 4'd7;
   localparam logic [3:0] FUNC_SHUTDOWN   = 4'd8;

   // Register indexes
   localparam logic [2:0] CSR_NODE_ID      = 3'd0;
   localparam logic [2:0] CSR_DEVICE_CLASS = 3'd1;
   localparam logic [2:0] CSR_WOR_ONLY     = 3'd2;
   localparam logic [2:0] CSR_NORMAL_INTV  = 3'd3;
   localparam logic [2:0] CSR_ALERT_INTV   = 3'd4;
   localparam logic [2:0] CSR_LOW_BATT     = 3'd5;
   localparam logic [2:0] CSR_OVER_TEMP    = 3'd6;

   // Fault bit positions
   localparam int FAULT_LOW_BATT_BIT = 0;
   localparam int FAULT_OVER_TEMP_BIT = 1;
   localparam int FAULT_CRITICAL_BIT = 2;

   // Hour arithmetic: 3600000 = 2^7 * 28125; the quotient of a 25 bit
   // value by 28125 is exact through a 26 bit reciprocal and a shift by 40.
   localparam logic [31:0] HOUR_MS     = 32'd3600000;
   localparam int          HOUR_PRESHIFT = 7;
   localparam int          DIV_IN_W    = 32 - HOUR_PRESHIFT;
   localparam int          RECIP_W     = 26;
   localparam logic [RECIP_W-1:0] HOUR_RECIP = 26'd39093747;
   localparam int          RECIP_SHIFT = 40;
   localparam int          PROD_W      = DIV_IN_W + RECIP_W;
   localparam int          HOURS_W     = PROD_W - RECIP_SHIFT;
   localparam logic [7:0]  UPTIME_MAX  = 8'd255;

   // Reset values
   localparam logic [31:0]        NORMAL_INTV_RESET = 32'd60000;
   localparam logic [31:0]        ALERT_INTV_RESET  = 32'd10000;
   localparam logic [7:0]         LOW_BATT_RESET    = 8'd10;
   localparam logic signed [7:0]  OVER_TEMP_RESET   = 8'sd70;
   localparam logic [7:0]         BATTERY_RESET     = 8'd100;
   localparam logic signed [7:0]  TEMP_RESET        = 8'sd25;

   typedef struct packed {
      logic [3:0]        func;
      logic [31:0]       now_ms;
      logic [7:0]        battery_in;
      logic signed [7:0] temperature_in;
      logic [7:0]        flag_mask;
   } event_type;

   typedef struct packed {
      logic [15:0]       node_id;
      logic [7:0]        device_class;
      logic              wor_only_mode;
      logic [31:0]       normal_interval_ms;
      logic [31:0]       alert_interval_ms;
      logic [7:0]        low_battery_pct;
      logic signed [7:0] over_temp_c;
   } cfg_type;

   typedef struct packed {
      logic [15:0]       node_id;
      logic [7:0]        battery;
      logic signed [7:0] temperature;
      logic [7:0]        faults;
      logic [7:0]        modules;
      logic [7:0]        uptime;
      logic [7:0]        device_class;
   } pkt_type;

endpackage

`default_nettype wire

// ===== hdl/status_report_timer.sv =====
// Top level of the status report timer: handshakes, registers and datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   req     | in        | req_valid / req_stall  | func, now_ms, battery, temp, mask
//   rsp     | out       | rsp_valid / rsp_stall  | status packet fields
//   csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// An accepted event lands in the input register, then commits against the device
// state. Tick first registers the reciprocal multiply for the hours, then commits
// the hour mark advance there; every other event commits straight from there.
// A packet loads into the result register at the same edge its event commits.
// Reset is synchronous: it empties both registers and returns the device state and the CSRs to their reset values.
// While rsp_stall holds a packet, the held event waits in the input register.
`default_nettype none

module status_report_timer (
   input  wire logic               clock,
   input  wire logic               reset,
   // event input
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_func,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic [7:0]         req_battery_in,
   input  wire logic signed [7:0]  req_temperature_in,
   input  wire logic [7:0]         req_flag_mask,
   // packet output
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_packet_sent,
   output logic [15:0]             rsp_pkt_node_id,
   output logic [7:0]              rsp_pkt_battery,
   output logic signed [7:0]       rsp_pkt_temperature,
   output logic [7:0]              rsp_pkt_faults,
   output logic [7:0]              rsp_pkt_modules,
   output logic [7:0]              rsp_pkt_uptime_hours,
   output logic [7:0]              rsp_pkt_device_class,
   // register writes
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import srt_pkg::*;

   cfg_type            cfg_ff;
   event_type          ev_ff;
   logic               in_valid_ff;
   logic               phase_ff;
   logic               rsp_valid_ff;
   pkt_type            pkt_ff;

   logic               req_take;
   logic               out_ready;
   logic               is_tick;
   logic               done;
   logic               div_load;
   logic               send;
   pkt_type            pkt_next;
   logic [31:0]        hour_mark_ms;
   logic               first_tick_pending;
   logic [HOURS_W-1:0] hours;

   // Register writes; index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id            <= 16'd0;
         cfg_ff.device_class       <= 8'd0;
         cfg_ff.wor_only_mode      <= 1'b0;
         cfg_ff.normal_interval_ms <= NORMAL_INTV_RESET;
         cfg_ff.alert_interval_ms  <= ALERT_INTV_RESET;
         cfg_ff.low_battery_pct    <= LOW_BATT_RESET;
         cfg_ff.over_temp_c        <= OVER_TEMP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NODE_ID:      cfg_ff.node_id            <= csr_wdata[15:0];
            CSR_DEVICE_CLASS: cfg_ff.device_class       <= csr_wdata[7:0];
            CSR_WOR_ONLY:     cfg_ff.wor_only_mode      <= csr_wdata[0];
            CSR_NORMAL_INTV:  cfg_ff.normal_interval_ms <= csr_wdata;
            CSR_ALERT_INTV:   cfg_ff.alert_interval_ms  <= csr_wdata;
            CSR_LOW_BATT:     cfg_ff.low_battery_pct    <= csr_wdata[7:0];
            CSR_OVER_TEMP:    cfg_ff.over_temp_c        <= $signed(csr_wdata[7:0]);
            default: begin
            end
         endcase
      end
   end

   // Result register can take a packet when empty or draining this cycle.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign is_tick   = ev_ff.func == FUNC_TICK;
   // Tick loads the hours quotient before it can commit.
   assign div_load  = in_valid_ff && is_tick && !phase_ff;
   assign done      = in_valid_ff && out_ready && (!is_tick || phase_ff);
   assign req_stall = in_valid_ff && !done;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (done) begin
            in_valid_ff <= 1'b0;
         end
         if (done) begin
            phase_ff <= 1'b0;
         end else if (div_load) begin
            phase_ff <= 1'b1;
         end
      end
   end

   // Hold the event while it works through the datapath.
   always_ff @(posedge clock) begin
      if (req_take) begin
         ev_ff.func           <= req_func;
         ev_ff.now_ms         <= req_now_ms;
         ev_ff.battery_in     <= req_battery_in;
         ev_ff.temperature_in <= req_temperature_in;
         ev_ff.flag_mask      <= req_flag_mask;
      end
   end

   srt_hour_div u_hour_div (
      .clock              (clock),
      .load               (div_load),
      .now_ms             (ev_ff.now_ms),
      .hour_mark_ms       (hour_mark_ms),
      .first_tick_pending (first_tick_pending),
      .hours              (hours)
   );

   srt_events u_events (
      .clock              (clock),
      .reset              (reset),
      .commit             (done),
      .ev                 (ev_ff),
      .cfg                (cfg_ff),
      .hours              (hours),
      .send               (send),
      .pkt                (pkt_next),
      .hour_mark_ms       (hour_mark_ms),
      .first_tick_pending (first_tick_pending)
   );

   // Result register: load on a sending commit, drop on transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && send) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && send) begin
         pkt_ff <= pkt_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_packet_sent      = 1'b1;
   assign rsp_pkt_node_id      = pkt_ff.node_id;
   assign rsp_pkt_battery      = pkt_ff.battery;
   assign rsp_pkt_temperature  = pkt_ff.temperature;
   assign rsp_pkt_faults       = pkt_ff.faults;
   assign rsp_pkt_modules      = pkt_ff.modules;
   assign rsp_pkt_uptime_hours = pkt_ff.uptime;
   assign rsp_pkt_device_class = pkt_ff.device_class;

endmodule

`default_nettype wire

// ===== hdl/srt_hour_div.sv =====
// Registered whole-hour quotient of the time since the hour mark.
`default_nettype none

module srt_hour_div (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic [31:0]                 now_ms,
   input  wire logic [31:0]                 hour_mark_ms,
   input  wire logic                        first_tick_pending,
   output logic [srt_pkg::HOURS_W-1:0]      hours
);
   import srt_pkg::*;

   logic [31:0]          elapsed;
   logic [PROD_W-1:0]    prod;
   logic [HOURS_W-1:0]   hours_ff;

   // The first tick moves the hour mark to now, so nothing has elapsed.
   assign elapsed = first_tick_pending ? 32'd0 : now_ms - hour_mark_ms;
   assign prod    = {{RECIP_W{1'b0}}, elapsed[31:HOUR_PRESHIFT]} *
                    {{DIV_IN_W{1'b0}}, HOUR_RECIP};

   always_ff @(posedge clock) begin
      if (load) begin
         hours_ff <= prod[PROD_W-1:RECIP_SHIFT];
      end
   end

   assign hours = hours_ff;

endmodule

`default_nettype wire

// ===== hdl/srt_events.sv =====
// Device state registers and the per-event update and packet logic.
`default_nettype none

module srt_events (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        commit,
   input  wire srt_pkg::event_type          ev,
   input  wire srt_pkg::cfg_type            cfg,
   input  wire logic [srt_pkg::HOURS_W-1:0] hours,
   output logic                             send,
   output srt_pkg::pkt_type                 pkt,
   output logic [31:0]                      hour_mark_ms,
   output logic                             first_tick_pending
);
   import srt_pkg::*;

   logic [7:0]        battery_ff, battery_in;
   logic signed [7:0] temp_ff, temp_in;
   logic [7:0]        faults_ff, faults_in;
   logic [7:0]        modules_ff, modules_in;
   logic [31:0]       hour_mark_ff, hour_mark_in;
   logic [7:0]        uptime_ff, uptime_in;
   logic [31:0]       last_report_ff, last_report_in;
   logic              first_ff, first_in;

   logic [31:0]       interval;
   logic [31:0]       hour_base;
   logic [31:0]       last_base;
   logic [31:0]       since_report;
   logic [11:0]       uptime_sum;
   logic              low_batt;
   logic              too_hot;
   logic [7:0]        derived;

   assign interval   = (faults_ff != 8'd0) ? cfg.alert_interval_ms : cfg.normal_interval_ms;
   assign hour_base  = first_ff ? ev.now_ms : hour_mark_ff;
   assign last_base  = first_ff ? ev.now_ms - interval : last_report_ff;
   assign since_report = ev.now_ms - last_base;
   assign uptime_sum = {4'd0, uptime_ff} + {{(12 - HOURS_W){1'b0}}, hours};

   // Rederive the automatic fault bits from the levels after this event.
   always_comb begin
      low_batt  = battery_in < cfg.low_battery_pct;
      too_hot   = $signed(temp_in) > $signed(cfg.over_temp_c);
      derived   = faults_ff;
      derived[FAULT_LOW_BATT_BIT]  = low_batt;
      derived[FAULT_OVER_TEMP_BIT] = too_hot;
      derived[FAULT_CRITICAL_BIT]  = low_batt & too_hot;
   end

   always_comb begin
      battery_in     = battery_ff;
      temp_in        = temp_ff;
      faults_in      = faults_ff;
      modules_in     = modules_ff;
      hour_mark_in   = hour_mark_ff;
      uptime_in      = uptime_ff;
      last_report_in = last_report_ff;
      first_in       = first_ff;
      send           = 1'b0;
      case (ev.func)
         FUNC_TICK: begin
            first_in     = 1'b0;
            hour_mark_in = hour_base + 32'({{(32 - HOURS_W){1'b0}}, hours} * HOUR_MS);
            uptime_in    = (uptime_sum > {4'd0, UPTIME_MAX}) ? UPTIME_MAX : uptime_sum[7:0];
            if (!cfg.wor_only_mode && (since_report >= interval)) begin
               send           = 1'b1;
               last_report_in = ev.now_ms;
            end else begin
               last_report_in = last_base;
            end
         end
         FUNC_SCAN: begin
            send = 1'b1;
         end
         FUNC_SET_BATT: begin
            battery_in = ev.battery_in;
            faults_in  = derived;
         end
         FUNC_SET_TEMP: begin
            temp_in   = ev.temperature_in;
            faults_in = derived;
         end
         FUNC_SET_FAULT:  faults_in  = faults_ff | ev.flag_mask;
         FUNC_CLR_FAULT:  faults_in  = faults_ff & ~ev.flag_mask;
         FUNC_SET_MODULE: modules_in = modules_ff | ev.flag_mask;
         FUNC_CLR_MODULE: modules_in = modules_ff & ~ev.flag_mask;
         FUNC_SHUTDOWN: begin
            faults_in  = 8'd0;
            modules_in = 8'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         battery_ff     <= BATTERY_RESET;
         temp_ff        <= TEMP_RESET;
         faults_ff      <= 8'd0;
         modules_ff     <= 8'd0;
         hour_mark_ff   <= 32'd0;
         uptime_ff      <= 8'd0;
         last_report_ff <= 32'd0;
         first_ff       <= 1'b1;
      end else if (commit) begin
         battery_ff     <= battery_in;
         temp_ff        <= temp_in;
         faults_ff      <= faults_in;
         modules_ff     <= modules_in;
         hour_mark_ff   <= hour_mark_in;
         uptime_ff      <= uptime_in;
         last_report_ff <= last_report_in;
         first_ff       <= first_in;
      end
   end

   // Packet shows the state after the event.
   always_comb begin
      pkt.node_id      = cfg.node_id;
      pkt.battery      = battery_in;
      pkt.temperature  = temp_in;
      pkt.faults       = faults_in;
      pkt.modules      = modules_in;
      pkt.uptime       = uptime_in;
      pkt.device_class = cfg.device_class;
   end

   assign hour_mark_ms       = hour_mark_ff;
   assign first_tick_pending = first_ff;

endmodule

`default_nettype wire

// ===== hdl/srt_checker.sv =====
// Port-level checks of the status report timer and their bind.
`default_nettype none

`include "status_report_timer_macros.svh"

module srt_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_packet_sent,
   input wire logic [15:0]        rsp_pkt_node_id,
   input wire logic [7:0]         rsp_pkt_battery,
   input wire logic signed [7:0]  rsp_pkt_temperature,
   input wire logic [7:0]         rsp_pkt_faults,
   input wire logic [7:0]         rsp_pkt_modules,
   input wire logic [7:0]         rsp_pkt_uptime_hours,
   input wire logic [7:0]         rsp_pkt_device_class
);

   // Block comes out of reset empty: nothing stalled, nothing to deliver.
   `SRT_ASSERT_NOW(a_empty_after_reset, $past(reset), !req_stall && !rsp_valid)

   // Every delivered result is a sent packet.
   `SRT_ASSERT_NOW(a_packet_flag, rsp_valid, rsp_packet_sent)

   // Stalled packet stays offered.
   `SRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // Stalled packet keeps its contents.
   `SRT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_pkt_node_id) && $stable(rsp_pkt_battery) &&
      $stable(rsp_pkt_temperature) && $stable(rsp_pkt_faults) &&
      $stable(rsp_pkt_modules) && $stable(rsp_pkt_uptime_hours) &&
      $stable(rsp_pkt_device_class))

endmodule

bind status_report_timer srt_checker u_srt_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the status report timer: event stimulus, packet prediction and checks.
module testbench;
   import srt_pkg::*;

   // Run shape
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 166;
   localparam int SETTLE_CYCLES   = 16;    // covers the tick commit path plus the result register
   localparam int QUIET_LIMIT     = 4000;  // cycles with no transfer on either channel

   // Codes outside the defined event set; the block must ignore them
   localparam logic [3:0] FUNC_FIRST_UNUSED = FUNC_SHUTDOWN + 4'd1;
   localparam logic [3:0] FUNC_LAST_UNUSED  = 4'hF;

   // Fault bits that follow battery and temperature
   localparam logic [7:0] DERIVED_FAULTS = (8'd1 << FAULT_LOW_BATT_BIT)
                                         | (8'd1 << FAULT_OVER_TEMP_BIT)
                                         | (8'd1 << FAULT_CRITICAL_BIT);

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Event channel
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [3:0]        req_func = FUNC_SCAN;
   logic [31:0]       req_now_ms = '0;
   logic [7:0]        req_battery_in = '0;
   logic signed [7:0] req_temperature_in = '0;
   logic [7:0]        req_flag_mask = '0;

   // Packet channel
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_packet_sent;
   logic [15:0]       rsp_pkt_node_id;
   logic [7:0]        rsp_pkt_battery;
   logic signed [7:0] rsp_pkt_temperature;
   logic [7:0]        rsp_pkt_faults;
   logic [7:0]        rsp_pkt_modules;
   logic [7:0]        rsp_pkt_uptime_hours;
   logic [7:0]        rsp_pkt_device_class;

   // Register write port
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index = CSR_NODE_ID;
   logic [31:0]       csr_wdata = '0;

   status_report_timer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_now_ms           (req_now_ms),
      .req_battery_in       (req_battery_in),
      .req_temperature_in   (req_temperature_in),
      .req_flag_mask        (req_flag_mask),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_packet_sent      (rsp_packet_sent),
      .rsp_pkt_node_id      (rsp_pkt_node_id),
      .rsp_pkt_battery      (rsp_pkt_battery),
      .rsp_pkt_temperature  (rsp_pkt_temperature),
      .rsp_pkt_faults       (rsp_pkt_faults),
      .rsp_pkt_modules      (rsp_pkt_modules),
      .rsp_pkt_uptime_hours (rsp_pkt_uptime_hours),
      .rsp_pkt_device_class (rsp_pkt_device_class),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Device shadow: register settings and state as the block should hold them
   // ------------------------------------------------------------------
   cfg_type settings = '{
      node_id:            '0,
      device_class:       '0,
      wor_only_mode:      1'b0,
      normal_interval_ms: NORMAL_INTV_RESET,
      alert_interval_ms:  ALERT_INTV_RESET,
      low_battery_pct:    LOW_BATT_RESET,
      over_temp_c:        OVER_TEMP_RESET
   };

   logic [7:0]        battery_level      = BATTERY_RESET;
   logic signed [7:0] temperature_level  = TEMP_RESET;
   logic [7:0]        fault_bits         = '0;
   logic [7:0]        module_bits        = '0;
   logic [31:0]       hour_mark_ms       = '0;
   logic [7:0]        uptime_count       = '0;
   logic [31:0]       last_report_ms     = '0;
   logic              first_tick_pending = 1'b1;

   event_type event_queue[$];      // events waiting for the driver
   pkt_type   expected_packets[$]; // packets owed by the block, oldest first
   event_type event_on_wire;       // payload currently presented on req_

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          error_count   = 0;
   int          quiet_cycles  = 0;
   logic [31:0] timeline_ms   = '0;  // running clock for generated ticks
   bit          wild_jumps    = 1'b0;

   // Report period in force: the alert period while any fault is up
   function automatic logic [31:0] report_interval();
      return (fault_bits != 8'd0) ? settings.alert_interval_ms : settings.normal_interval_ms;
   endfunction

   // Recompute low battery, over temperature and critical; leave the other fault bits
   function automatic void rederive_faults();
      logic low_batt;
      logic too_hot;
      low_batt  = battery_level < settings.low_battery_pct;
      too_hot   = $signed(temperature_level) > $signed(settings.over_temp_c);
      fault_bits = fault_bits & ~DERIVED_FAULTS;
      fault_bits[FAULT_LOW_BATT_BIT]  = low_batt;
      fault_bits[FAULT_OVER_TEMP_BIT] = too_hot;
      fault_bits[FAULT_CRITICAL_BIT]  = low_batt && too_hot;
   endfunction

   // Apply one event to the shadow state; return 1 when it sends a status packet
   function automatic bit advance_device(input event_type ev, output pkt_type pkt);
      logic [31:0] hours;
      logic [31:0] hour_sum;
      logic [31:0] since_report;
      bit          sends;
      sends = 1'b0;
      case (ev.func)
         FUNC_TICK: begin
            // Prime the timer on the very first tick so a report leaves at once
            if (first_tick_pending) begin
               hour_mark_ms       = ev.now_ms;
               last_report_ms     = ev.now_ms - report_interval();
               first_tick_pending = 1'b0;
            end
            hours        = (ev.now_ms - hour_mark_ms) / HOUR_MS;
            hour_sum     = hours + 32'(uptime_count);
            uptime_count = (hour_sum > 32'(UPTIME_MAX)) ? UPTIME_MAX : hour_sum[7:0];
            hour_mark_ms = hour_mark_ms + hours * HOUR_MS;
            since_report = ev.now_ms - last_report_ms;
            if (!settings.wor_only_mode && since_report >= report_interval()) begin
               last_report_ms = ev.now_ms;
               sends = 1'b1;
            end
         end
         FUNC_SCAN: sends = 1'b1;
         FUNC_SET_BATT: begin
            battery_level = ev.battery_in;
            rederive_faults();
         end
         FUNC_SET_TEMP: begin
            temperature_level = ev.temperature_in;
            rederive_faults();
         end
         FUNC_SET_FAULT:  fault_bits  = fault_bits | ev.flag_mask;
         FUNC_CLR_FAULT:  fault_bits  = fault_bits & ~ev.flag_mask;
         FUNC_SET_MODULE: module_bits = module_bits | ev.flag_mask;
         FUNC_CLR_MODULE: module_bits = module_bits & ~ev.flag_mask;
         FUNC_SHUTDOWN: begin
            fault_bits  = '0;
            module_bits = '0;
         end
         default: ;  // unused codes change nothing
      endcase
      pkt.node_id      = settings.node_id;
      pkt.battery      = battery_level;
      pkt.temperature  = temperature_level;
      pkt.faults       = fault_bits;
      pkt.modules      = module_bits;
      pkt.uptime       = uptime_count;
      pkt.device_class = settings.device_class;
      return sends;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_event(input logic [3:0] func, input logic [31:0] now_ms,
                                       input logic [7:0] battery,
                                       input logic signed [7:0] temp,
                                       input logic [7:0] mask);
      event_type ev;
      ev.func           = func;
      ev.now_ms         = now_ms;
      ev.battery_in     = battery;
      ev.temperature_in = temp;
      ev.flag_mask      = mask;
      event_queue.push_back(ev);
   endfunction

   // Ticks most often, on an advancing timeline; thresholds are probed from both sides
   function automatic event_type random_event();
      event_type   ev;
      int          pick;
      int          step_kind;
      logic [31:0] delta;
      pick              = $urandom_range(99);
      ev.battery_in     = 8'($urandom_range(255));
      ev.temperature_in = 8'($urandom_range(255));
      ev.flag_mask      = 8'($urandom_range(255));
      ev.now_ms         = ($urandom_range(1) == 0) ? $urandom() : timeline_ms;
      if (pick < 40)      ev.func = FUNC_TICK;
      else if (pick < 55) ev.func = FUNC_SCAN;
      else if (pick < 64) ev.func = FUNC_SET_BATT;
      else if (pick < 73) ev.func = FUNC_SET_TEMP;
      else if (pick < 78) ev.func = FUNC_SET_FAULT;
      else if (pick < 83) ev.func = FUNC_CLR_FAULT;
      else if (pick < 88) ev.func = FUNC_SET_MODULE;
      else if (pick < 93) ev.func = FUNC_CLR_MODULE;
      else if (pick < 96) ev.func = FUNC_SHUTDOWN;
      else                ev.func = 4'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));

      // Hover around the fault thresholds half of the time
      if (ev.func == FUNC_SET_BATT && $urandom_range(1) == 0)
         ev.battery_in = settings.low_battery_pct + 8'($urandom_range(4)) - 8'd2;
      if (ev.func == FUNC_SET_TEMP && $urandom_range(1) == 0)
         ev.temperature_in = settings.over_temp_c + 8'($urandom_range(4)) - 8'sd2;

      if (ev.func == FUNC_TICK) begin
         step_kind = $urandom_range(99);
         if (step_kind < 10)      delta = '0;
         else if (step_kind < 55) delta = $urandom_range(20000);
         else if (step_kind < 80) delta = $urandom_range(200000);
         else if (step_kind < 92) delta = $urandom_range(3 * HOUR_MS);
         else if (wild_jumps)     delta = $urandom();
         else                     delta = $urandom_range(65535);
         timeline_ms = timeline_ms + delta;
         ev.now_ms   = timeline_ms;
      end
      return ev;
   endfunction

   // One register write, landing on the following rising edge
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
   endtask

   // Write every register in index order and mirror the values in the shadow
   task automatic apply_settings(input cfg_type c);
      settings = c;
      write_reg(CSR_NODE_ID,      {16'd0, c.node_id});
      write_reg(CSR_DEVICE_CLASS, {24'd0, c.device_class});
      write_reg(CSR_WOR_ONLY,     {31'd0, c.wor_only_mode});
      write_reg(CSR_NORMAL_INTV,  c.normal_interval_ms);
      write_reg(CSR_ALERT_INTV,   c.alert_interval_ms);
      write_reg(CSR_LOW_BATT,     {24'd0, c.low_battery_pct});
      write_reg(CSR_OVER_TEMP,    {24'd0, c.over_temp_c});
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every event is taken and every packet is back, then let the
   // tick path settle, since most events send nothing
   task automatic wait_until_idle();
      do @(negedge clock);
      while (event_queue.size() != 0 || req_valid || expected_packets.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: present the next event once the current one transfers.
   // The shadow advances at the edge that accepts the event.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pkt_type next_pkt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid && advance_device(event_on_wire, next_pkt))
            expected_packets.push_back(next_pkt);
         if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            event_on_wire = event_queue.pop_front();
            req_valid          <= 1'b1;
            req_func           <= event_on_wire.func;
            req_now_ms         <= event_on_wire.now_ms;
            req_battery_in     <= event_on_wire.battery_in;
            req_temperature_in <= event_on_wire.temperature_in;
            req_flag_mask      <= event_on_wire.flag_mask;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each packet transfer against the oldest expectation,
   // and throttle the packet channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pkt_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_packets.size() == 0) begin
               $display("%0t: unexpected packet: expected none, got node %0h uptime %0h",
                        $time, rsp_pkt_node_id, rsp_pkt_uptime_hours);
               error_count++;
            end else begin
               want = expected_packets.pop_front();
               compare_field("packet_sent",  32'd1,                 32'(rsp_packet_sent));
               compare_field("node_id",      32'(want.node_id),     32'(rsp_pkt_node_id));
               compare_field("battery",      32'(want.battery),     32'(rsp_pkt_battery));
               compare_field("temperature",  32'(want.temperature),
                             32'(rsp_pkt_temperature));
               compare_field("faults",       32'(want.faults),      32'(rsp_pkt_faults));
               compare_field("modules",      32'(want.modules),     32'(rsp_pkt_modules));
               compare_field("uptime",       32'(want.uptime),
                             32'(rsp_pkt_uptime_hours));
               compare_field("device_class", 32'(want.device_class),
                             32'(rsp_pkt_device_class));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run when neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int      sender_idle_by_phase[4];
      int      stall_by_phase[4];
      cfg_type next_cfg;
      sender_idle_by_phase = '{0, 79, 0, 30};
      stall_by_phase       = '{0, 0, 79, 30};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part on the reset settings: normal 60000, alert 10000,
      // low battery below 10, over temperature above 70
      queue_event(FUNC_SCAN,       32'd0,          8'd0,   -8'sd128, 8'h00); // reset state
      queue_event(FUNC_TICK,       32'd5000,       8'd0,   8'sd0,    8'h00); // first tick reports
      queue_event(FUNC_TICK,       32'd5001,       8'd0,   8'sd0,    8'h00);
      queue_event(FUNC_TICK,       32'd65000,      8'd0,   8'sd0,    8'h00); // exactly one period
      queue_event(FUNC_TICK,       32'd124999,     8'd0,   8'sd0,    8'h00); // one short
      queue_event(FUNC_SET_BATT,   32'd0,          8'd0,   8'sd0,    8'h00); // low battery
      queue_event(FUNC_SET_TEMP,   32'd0,          8'd0,   8'sd127,  8'h00); // hot, critical
      queue_event(FUNC_TICK,       32'd75000,      8'd0,   8'sd0,    8'h00); // alert period
      queue_event(FUNC_SET_BATT,   32'hFFFF_FFFF,  8'd255, 8'sd0,    8'hFF);
      queue_event(FUNC_SET_TEMP,   32'd0,          8'd0,   -8'sd128, 8'h00);
      queue_event(FUNC_SCAN,       32'd0,          8'd0,   8'sd0,    8'h00);
      queue_event(FUNC_SET_FAULT,  32'd0,          8'd0,   8'sd0,    8'hFF);
      queue_event(FUNC_CLR_FAULT,  32'd0,          8'd0,   8'sd0,    8'h0F);
      queue_event(FUNC_SET_MODULE, 32'd0,          8'd0,   8'sd0,    8'hFF);
      queue_event(FUNC_CLR_MODULE, 32'd0,          8'd0,   8'sd0,    8'h55);
      queue_event(FUNC_SET_TEMP,   32'd0,          8'd0,   8'sd70,   8'h00); // at limit, not hot
      queue_event(FUNC_SET_BATT,   32'd0,          8'd10,  8'sd0,    8'h00); // at limit, not low
      queue_event(FUNC_SCAN,       32'd0,          8'd0,   8'sd0,    8'h00);
      queue_event(FUNC_SHUTDOWN,   32'd0,          8'd0,   8'sd0,    8'h00);
      queue_event(FUNC_LAST_UNUSED,  $urandom(), 8'hFF, -8'sd1,  8'hFF);     // ignored
      queue_event(FUNC_FIRST_UNUSED, $urandom(), 8'h00, 8'sd0,   8'h00);     // ignored
      queue_event(FUNC_SCAN,       32'd0,          8'd0,   8'sd0,    8'h00);
      queue_event(FUNC_TICK,       32'd75000 + 3 * HOUR_MS + 32'd7, 8'd0, 8'sd0, 8'h00);
      queue_event(FUNC_TICK,       32'hFFFF_FFFF,  8'd0,   8'sd0,    8'h00); // long jump
      queue_event(FUNC_TICK,       32'h0000_0100,  8'd0,   8'sd0,    8'h00); // timestamp wraps
      timeline_ms = 32'h0000_0100;
      wait_until_idle();

      // Random phases, each under its own settings and one of four idling patterns
      for (int phase = 0; phase < PHASES; phase++) begin
         next_cfg.node_id            = 16'($urandom());
         next_cfg.device_class       = 8'($urandom());
         next_cfg.wor_only_mode      = 1'b0;
         next_cfg.normal_interval_ms = $urandom_range(100000, 1000);
         next_cfg.alert_interval_ms  = $urandom_range(20000, 100);
         next_cfg.low_battery_pct    = 8'($urandom_range(100));
         next_cfg.over_temp_c        = 8'($urandom_range(255));
         case (phase)
            0: begin
               // every field at its top, but the normal period at 1 and the over temperature limit at its bottom
               next_cfg.node_id            = 16'hFFFF;
               next_cfg.device_class       = 8'hFF;
               next_cfg.normal_interval_ms = 32'd1;
               next_cfg.alert_interval_ms  = 32'hFFFF_FFFF;
               next_cfg.low_battery_pct    = 8'hFF;
               next_cfg.over_temp_c        = -8'sd128;
            end
            1: begin
               // zero periods: every active tick reports
               next_cfg.node_id            = 16'h0000;
               next_cfg.device_class       = 8'h00;
               next_cfg.normal_interval_ms = 32'd0;
               next_cfg.alert_interval_ms  = 32'd0;
               next_cfg.low_battery_pct    = 8'd0;
               next_cfg.over_temp_c        = 8'sd127;
            end
            3: begin
               // scans only; start close to the timestamp wrap
               next_cfg.wor_only_mode      = 1'b1;
               next_cfg.normal_interval_ms = 32'hFFFF_FFFF;
               next_cfg.alert_interval_ms  = 32'd1;
               next_cfg.low_battery_pct    = 8'd50;
               next_cfg.over_temp_c        = 8'sd0;
               timeline_ms                 = 32'hFFF0_0000;
               wild_jumps                  = 1'b1;
            end
            4: next_cfg.wor_only_mode = 1'($urandom_range(1));
            default: ;
         endcase
         apply_settings(next_cfg);
         send_idle_pct = sender_idle_by_phase[phase % 4];
         stall_pct     = stall_by_phase[phase % 4];
         repeat (ITEMS_PER_PHASE) event_queue.push_back(random_event());
         wait_until_idle();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
